// File: hw/rtl/ihex_pkg.sv
// ihex_pkg: shared types and codes for the hex record parser
// item structs for both channels, classified character, result and error codes
// no dependencies
package ihex_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic       req_type;
        logic [7:0] character;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [7:0]  data_byte;
        logic [2:0]  error_code;
        logic [31:0] record_count;
        logic [31:0] start_address;
    } t_out_item;

    typedef struct packed {
        logic       restart;
        logic       colon;
        logic       cr;
        logic       lf;
        logic [3:0] nibble;
    } t_cls;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_EOF    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_START     = 3'd1;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd2;
    localparam logic [2:0] ERR_LINE_END  = 3'd3;
    localparam logic [2:0] ERR_EOF_LEN   = 3'd4;
    localparam logic [2:0] ERR_SEG_LEN   = 3'd5;
    localparam logic [2:0] ERR_LIN_LEN   = 3'd6;
    localparam logic [2:0] ERR_BAD_TYPE  = 3'd7;

    localparam logic [7:0] REC_DATA      = 8'd0;
    localparam logic [7:0] REC_EOF       = 8'd1;
    localparam logic [7:0] REC_SEG_BASE  = 8'd2;
    localparam logic [7:0] REC_SEG_START = 8'd3;
    localparam logic [7:0] REC_LIN_BASE  = 8'd4;
    localparam logic [7:0] REC_LIN_START = 8'd5;

endpackage

// File: hw/rtl/ihex_front.sv
// ihex_front: accepts input items and classifies each character
// decodes the hex nibble and marks colon, cr, lf and restart
// depends on ihex_pkg
module ihex_front (
    input  logic              i_valid,
    input  ihex_pkg::t_in_item i_item,
    input  logic              i_queue_full,
    output logic              o_stall,
    output logic              o_push,
    output ihex_pkg::t_cls    o_cls
);

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_UA    = 8'd65;
    localparam logic [7:0] CHAR_UF    = 8'd70;
    localparam logic [7:0] ALPHA_OFS  = 8'd55;

    logic [7:0] c;
    logic [7:0] diff;

    assign c       = i_item.character;
    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        diff = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff = c - CHAR_ZERO;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            diff = c - ALPHA_OFS;
        end
        o_cls.restart = i_item.req_type;
        o_cls.colon   = (c == CHAR_COLON);
        o_cls.cr      = (c == CHAR_CR);
        o_cls.lf      = (c == CHAR_LF);
        o_cls.nibble  = diff[3:0];
    end

endmodule

// File: hw/rtl/ihex_queue.sv
// ihex_queue: short fifo of classified items between front and back
// register array with read and write pointers and a fill count
// depends on ihex_pkg
module ihex_queue #(
    parameter int DEPTH = ihex_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ihex_pkg::t_cls i_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output ihex_pkg::t_cls o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    ihex_pkg::t_cls r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic           do_pop;

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/ihex_back.sv
// ihex_back: record state machine, address extension and result register
// takes classified items from the queue, one per cycle while results drain
// depends on ihex_pkg
module ihex_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  ihex_pkg::t_cls      i_q_data,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output ihex_pkg::t_out_item o_item
);

    typedef enum logic [3:0] {
        PH_COLON, PH_LENGTH, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE,
        PH_DATA, PH_CHECK, PH_LINEEND, PH_LF
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_pend, n_pend;
    logic [3:0]  r_high, n_high;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_idx, n_idx;
    logic [15:0] r_raddr, n_raddr;
    logic [7:0]  r_rkind, n_rkind;
    logic [7:0]  r_sum, n_sum;
    logic [31:0] r_hold, n_hold;
    logic [31:0] r_base, n_base;
    logic [31:0] r_entry, n_entry;
    logic [31:0] r_lines, n_lines;
    logic        r_halt, n_halt;

    logic                r_out_valid;
    ihex_pkg::t_out_item r_out;

    logic        go;
    logic        emit;
    logic [1:0]  e_kind;
    logic [31:0] e_addr;
    logic [7:0]  e_data;
    logic [2:0]  e_err;
    logic [7:0]  b;

    assign go      = i_q_valid && (!r_out_valid || !i_stall);
    assign o_q_pop = go;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;
    assign b       = {r_high, i_q_data.nibble};

    always_comb begin
        n_phase = r_phase;
        n_pend  = r_pend;
        n_high  = r_high;
        n_len   = r_len;
        n_idx   = r_idx;
        n_raddr = r_raddr;
        n_rkind = r_rkind;
        n_sum   = r_sum;
        n_hold  = r_hold;
        n_base  = r_base;
        n_entry = r_entry;
        n_lines = r_lines;
        n_halt  = r_halt;
        emit    = 1'b0;
        e_kind  = ihex_pkg::KIND_ACCEPT;
        e_addr  = 32'd0;
        e_data  = 8'd0;
        e_err   = ihex_pkg::ERR_NONE;
        if (i_q_data.restart) begin
            n_phase = PH_COLON;
            n_pend  = 1'b0;
            n_high  = 4'd0;
            n_len   = 8'd0;
            n_idx   = 8'd0;
            n_raddr = 16'd0;
            n_rkind = 8'd0;
            n_sum   = 8'd0;
            n_hold  = 32'd0;
            n_base  = 32'd0;
            n_entry = 32'd0;
            n_lines = 32'd0;
            n_halt  = 1'b0;
        end else if (!r_halt) begin
            case (r_phase)
                PH_COLON: begin
                    if (i_q_data.colon) begin
                        n_pend  = 1'b0;
                        n_phase = PH_LENGTH;
                    end else begin
                        emit   = 1'b1;
                        e_kind = ihex_pkg::KIND_ERROR;
                        e_err  = ihex_pkg::ERR_START;
                    end
                end
                PH_LINEEND, PH_LF: begin
                    if (i_q_data.cr && r_phase == PH_LINEEND) begin
                        n_phase = PH_LF;
                    end else if (i_q_data.lf) begin
                        emit    = 1'b1;
                        n_phase = PH_COLON;
                        if (r_sum != 8'd0) begin
                            e_kind = ihex_pkg::KIND_ERROR;
                            e_err  = ihex_pkg::ERR_CHECKSUM;
                        end else begin
                            case (r_rkind)
                                ihex_pkg::REC_DATA: ;
                                ihex_pkg::REC_EOF: begin
                                    if (r_len != 8'd0) begin
                                        e_kind = ihex_pkg::KIND_ERROR;
                                        e_err  = ihex_pkg::ERR_EOF_LEN;
                                    end else begin
                                        e_kind = ihex_pkg::KIND_EOF;
                                    end
                                end
                                ihex_pkg::REC_SEG_BASE: begin
                                    if (r_len != 8'd2) begin
                                        e_kind = ihex_pkg::KIND_ERROR;
                                        e_err  = ihex_pkg::ERR_SEG_LEN;
                                    end else begin
                                        n_base = {12'd0, r_hold[15:0], 4'd0};
                                    end
                                end
                                ihex_pkg::REC_SEG_START, ihex_pkg::REC_LIN_START: begin
                                    n_entry = r_hold;
                                end
                                ihex_pkg::REC_LIN_BASE: begin
                                    if (r_len != 8'd2) begin
                                        e_kind = ihex_pkg::KIND_ERROR;
                                        e_err  = ihex_pkg::ERR_LIN_LEN;
                                    end else begin
                                        n_base = {r_hold[15:0], 16'd0};
                                    end
                                end
                                default: begin
                                    e_kind = ihex_pkg::KIND_ERROR;
                                    e_err  = ihex_pkg::ERR_BAD_TYPE;
                                end
                            endcase
                        end
                    end else begin
                        emit   = 1'b1;
                        e_kind = ihex_pkg::KIND_ERROR;
                        e_err  = ihex_pkg::ERR_LINE_END;
                    end
                end
                PH_LENGTH, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE, PH_DATA, PH_CHECK: begin
                    if (!r_pend) begin
                        n_high = i_q_data.nibble;
                        n_pend = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                        case (r_phase)
                            PH_LENGTH: begin
                                n_len   = b;
                                n_sum   = b;
                                n_idx   = 8'd0;
                                n_hold  = 32'd0;
                                n_phase = PH_ADDR_HI;
                            end
                            PH_ADDR_HI: begin
                                n_raddr = {b, 8'd0};
                                n_sum   = r_sum + b;
                                n_phase = PH_ADDR_LO;
                            end
                            PH_ADDR_LO: begin
                                n_raddr = {r_raddr[15:8], b};
                                n_sum   = r_sum + b;
                                n_phase = PH_TYPE;
                            end
                            PH_TYPE: begin
                                n_rkind = b;
                                n_sum   = r_sum + b;
                                n_phase = (r_len != 8'd0) ? PH_DATA : PH_CHECK;
                            end
                            PH_DATA: begin
                                n_sum  = r_sum + b;
                                n_hold = {r_hold[23:0], b};
                                n_idx  = r_idx + 8'd1;
                                if (n_idx == r_len) begin
                                    n_phase = PH_CHECK;
                                end
                                if (r_rkind == ihex_pkg::REC_DATA) begin
                                    emit   = 1'b1;
                                    e_kind = ihex_pkg::KIND_DATA;
                                    e_addr = r_base + {16'd0, r_raddr} + {24'd0, r_idx};
                                    e_data = b;
                                end
                            end
                            default: begin
                                n_sum   = r_sum + b;
                                n_lines = r_lines + 32'd1;
                                n_phase = PH_LINEEND;
                            end
                        endcase
                    end
                end
                default: begin
                    n_phase = PH_COLON;
                end
            endcase
            if (emit && (e_kind == ihex_pkg::KIND_ERROR || e_kind == ihex_pkg::KIND_EOF)) begin
                n_halt = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_COLON;
            r_pend      <= 1'b0;
            r_high      <= 4'd0;
            r_len       <= 8'd0;
            r_idx       <= 8'd0;
            r_raddr     <= 16'd0;
            r_rkind     <= 8'd0;
            r_sum       <= 8'd0;
            r_hold      <= 32'd0;
            r_base      <= 32'd0;
            r_entry     <= 32'd0;
            r_lines     <= 32'd0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (go) begin
                r_phase <= n_phase;
                r_pend  <= n_pend;
                r_high  <= n_high;
                r_len   <= n_len;
                r_idx   <= n_idx;
                r_raddr <= n_raddr;
                r_rkind <= n_rkind;
                r_sum   <= n_sum;
                r_hold  <= n_hold;
                r_base  <= n_base;
                r_entry <= n_entry;
                r_lines <= n_lines;
                r_halt  <= n_halt;
            end
            if (!r_out_valid || !i_stall) begin
                r_out_valid <= go && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            r_out.kind          <= e_kind;
            r_out.address       <= e_addr;
            r_out.data_byte     <= e_data;
            r_out.error_code    <= e_err;
            r_out.record_count  <= n_lines;
            r_out.start_address <= n_entry;
        end
    end

endmodule

// File: hw/rtl/intel_hex_record_parser_top.sv
// intel_hex_record_parser_top: hex record parser, one character per item
// front classifier, queue and back state machine; depends on ihex_pkg
//
// input channel: i_in_valid / o_in_stall carry one item of req_type and
// character; req_type 1 restarts the reader and gives no result.
// output channel: o_out_valid / i_out_stall carry zero or one result per
// item: provisional data bytes, record accepted, end of file or error.
// throughput: one item per cycle, sustained as long as results are taken.
// an item that gives a result is held in the queue, then in the result
// register, which raises o_out_valid; a stall can hold it in either
// (the queue, then the result register).
// after an error or end of file further characters give no result until
// a restart item.
// when the receiver stalls the result register holds, the back end stops,
// and the queue of QUEUE_DEPTH items fills before o_in_stall rises.
// reset: synchronous, active low; state clears as after a restart, the
// queue empties and no result is pending.
module intel_hex_record_parser_top #(
    parameter int QUEUE_DEPTH = ihex_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ihex_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ihex_pkg::t_out_item o_out_item
);

    logic           push;
    logic           full;
    logic           q_valid;
    logic           q_pop;
    ihex_pkg::t_cls cls;
    ihex_pkg::t_cls q_data;

    ihex_front u_front (
        .i_valid      (i_in_valid),
        .i_item       (i_in_item),
        .i_queue_full (full),
        .o_stall      (o_in_stall),
        .o_push       (push),
        .o_cls        (cls)
    );

    ihex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    ihex_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (o_out_item)
    );

endmodule
